// ----- rtl/crr_pkg.sv -----
// crr_pkg: shared types and constants for the chained range remap block.
// No dependencies.
`timescale 1ns / 1ps
package crr_pkg;
    localparam int MAX_STAGES_DEF      = 8;
    localparam int SLOTS_PER_STAGE_DEF = 32;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 4;
    localparam int MODE_W  = 2;
    localparam int STAGE_W = 3;
    localparam int SLOT_W  = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD = 2'd0,
        MODE_FWD  = 2'd1,
        MODE_INV  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    // token handed from one stage cell to the next
    typedef struct packed {
        logic             valid;
        logic             inverse;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
        logic             active;
    } tok_t;

    // window write broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [STAGE_W-1:0] stage;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0] src;
        logic [VAL_W-1:0] dst;
        logic [VAL_W-1:0] len;
    } wr_t;
endpackage

// ----- rtl/crr_cell.sv -----
// crr_cell: one remap stage; holds its windows in a memory and scans them
// one slot per cycle. Depends on crr_pkg.
`timescale 1ns / 1ps
module crr_cell
    import crr_pkg::*;
#(
    parameter int SLOTS   = SLOTS_PER_STAGE_DEF,
    parameter int STAGE_NUM = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  wr_t  wr,
    input  tok_t tok_in,
    output tok_t tok_out
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [3*VAL_W-1:0] mem [SLOTS];
    logic [SLOTS-1:0] vld_reg;
    logic [3*VAL_W-1:0] rd_reg;
    logic              rd_vld_reg;

    logic          busy_reg, busy_next;
    logic [SW:0]   ptr_reg, ptr_next;
    logic          chk_reg, chk_next;   // read data of slot ptr-1 is ready
    tok_t          cur_reg, cur_next;
    tok_t          out_reg, out_next;
    logic          done_reg, done_next;

    logic          wr_hit;
    assign wr_hit = wr.en && (32'(wr.stage) == STAGE_NUM) && (32'(wr.slot) < SLOTS);

    always_ff @(posedge aclk) begin
        if (wr_hit) mem[SW'(wr.slot)] <= {wr.len, wr.dst, wr.src};
        rd_reg <= mem[ptr_reg[SW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (wr_hit) begin
            vld_reg[SW'(wr.slot)] <= 1'b1;
        end
    end

    logic [VAL_W-1:0] w_src, w_dst, w_len, from, to;
    logic [VAL_W:0]   wend, r;
    logic             hit;
    always_comb begin
        w_src = rd_reg[VAL_W-1:0];
        w_dst = rd_reg[2*VAL_W-1:VAL_W];
        w_len = rd_reg[3*VAL_W-1:2*VAL_W];
        from  = cur_reg.inverse ? w_dst : w_src;
        to    = cur_reg.inverse ? w_src : w_dst;
        wend  = {1'b0, from} + {1'b0, w_len};
        r     = {1'b0, to} + {1'b0, cur_reg.value - from};
        hit   = chk_reg && rd_vld_reg && ({1'b0, cur_reg.value} >= {1'b0, from})
                && ({1'b0, cur_reg.value} < wend) && (r != {1'b0, cur_reg.value});
    end

    always_comb begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        chk_next  = 1'b0;
        cur_next  = cur_reg;
        out_next  = out_reg;
        done_next = 1'b0;
        out_next.valid = 1'b0;
        if (!busy_reg) begin
            if (tok_in.valid) begin
                cur_next = tok_in;
                if (tok_in.active) begin
                    busy_next = 1'b1;
                    ptr_next  = '0;
                end else begin
                    out_next  = tok_in;
                end
            end
        end else begin
            if (hit) begin
                cur_next.value = r[VAL_W] ? '1 : r[VAL_W-1:0];
                cur_next.count = cur_reg.count + 1'b1;
                out_next = cur_next;
                out_next.valid = 1'b1;
                busy_next = 1'b0;
            end else if (ptr_reg == (SW+1)'(SLOTS) && chk_reg == 1'b0 && done_reg) begin
                out_next = cur_reg;
                out_next.valid = 1'b1;
                busy_next = 1'b0;
            end else if (ptr_reg < (SW+1)'(SLOTS)) begin
                ptr_next = ptr_reg + 1'b1;
                chk_next = 1'b1;
            end else begin
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
            out_reg.valid <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            chk_reg  <= chk_next;
            done_reg <= done_next;
            out_reg.valid <= out_next.valid;
        end
        ptr_reg <= ptr_next;
        rd_vld_reg <= vld_reg[ptr_reg[SW-1:0]];
        cur_reg <= cur_next;
        out_reg.inverse <= out_next.inverse;
        out_reg.value   <= out_next.value;
        out_reg.count   <= out_next.count;
        out_reg.active  <= out_next.active;
    end

    assign tok_out = out_reg;
endmodule

// ----- rtl/crr_ctrl.sv -----
// crr_ctrl: input handshake, direction of the cell chain and output
// register. Depends on crr_pkg.
`timescale 1ns / 1ps
module crr_ctrl
    import crr_pkg::*;
#(
    parameter int MAX_STAGES = MAX_STAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [VAL_W-1:0]      lookup_value,
    input  logic [CNT_W-1:0]      stages_cfg,
    output tok_t                  head,
    output logic [4:0]            ncells,
    input  tok_t                  tail,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VAL_W-1:0]      m_value,
    output logic [CNT_W-1:0]      m_count
);
    logic busy_reg, busy_next;
    logic ov_reg, ov_next;
    logic [VAL_W-1:0] ovv_reg, ovv_next;
    logic [CNT_W-1:0] ovc_reg, ovc_next;
    logic acc, lookup;

    assign in_ready = !busy_reg && !ov_reg;
    assign acc      = in_valid && in_ready;
    assign lookup   = (mode == MODE_FWD) || (mode == MODE_INV);
    assign ncells   = (32'(stages_cfg) > MAX_STAGES) ? 5'(MAX_STAGES) : 5'(stages_cfg);

    always_comb begin
        head.valid   = acc && lookup;
        head.inverse = (mode == MODE_INV);
        head.value   = lookup_value;
        head.count   = '0;
        head.active  = 1'b1;
    end

    always_comb begin
        busy_next = busy_reg;
        ov_next   = ov_reg;
        ovv_next  = ovv_reg;
        ovc_next  = ovc_reg;
        if (acc && lookup) busy_next = 1'b1;
        if (m_valid && m_ready) ov_next = 1'b0;
        if (tail.valid) begin
            busy_next = 1'b0;
            ov_next   = 1'b1;
            ovv_next  = tail.value;
            ovc_next  = tail.count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            ov_reg   <= ov_next;
        end
        ovv_reg <= ovv_next;
        ovc_reg <= ovc_next;
    end

    assign m_valid = ov_reg;
    assign m_value = ovv_reg;
    assign m_count = ovc_reg;

    // with zero stages the result comes back in the accepting cycle
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !in_ready) else $error("accept while busy");
    a_tail_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (busy_reg || head.valid)) else $error("result without transaction");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_value))) else $error("out lost");
endmodule

// ----- rtl/chained_range_remap.sv -----
// Timing: a load is written into the addressed cell's window memory. A lookup
// result is returned once the token has passed N stage cells, N = stages in use
// (0 to 8): each stage cell scans its 32 window slots one per cycle from its
// memory and stops early at the first changing window.
// Throughput: one lookup in flight; no input is taken until its result is.
// Reset: synchronous active low; clears all window valid bits and sets
// stages_in_use to 1. No clearing pass.
`timescale 1ns / 1ps
module chained_range_remap
    import crr_pkg::*;
#(
    parameter int MAX_STAGES      = MAX_STAGES_DEF,
    parameter int SLOTS_PER_STAGE = SLOTS_PER_STAGE_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_data,     // stages_in_use
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [1:0]   s_tuser,         // [1:0] mode
    // [2:0] stage_index, [7:3] slot_index, [39:8] source_start,
    // [71:40] dest_start, [103:72] window_length, [135:104] lookup_value
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] result_value, [35:32] changed_stages
    output logic [39:0]  m_tdata
);
    logic [CNT_W-1:0] stages_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) stages_reg <= 4'd1;
        else if (cfg_wr_en) stages_reg <= cfg_wr_data;
    end

    logic [MODE_W-1:0] mode;
    assign mode = s_tuser;

    wr_t  wr;
    tok_t head, tail;
    logic [4:0] ncells;
    logic [VAL_W-1:0] mv;
    logic [CNT_W-1:0] mc;

    assign wr.en    = s_tvalid && s_tready && (mode == MODE_LOAD);
    assign wr.stage = s_tdata[2:0];
    assign wr.slot  = s_tdata[7:3];
    assign wr.src   = s_tdata[39:8];
    assign wr.dst   = s_tdata[71:40];
    assign wr.len   = s_tdata[103:72];

    crr_ctrl #(.MAX_STAGES(MAX_STAGES)) u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .mode,
        .lookup_value(s_tdata[135:104]), .stages_cfg(stages_reg),
        .head, .ncells, .tail,
        .m_valid(m_tvalid), .m_ready(m_tready), .m_value(mv), .m_count(mc)
    );

    // chain position p: forward visits stage p, inverse visits stage n-1-p.
    // Cells are per stage; the token walks positions and each stage cell is
    // picked by a mux, keeping the row of identical cells.
    tok_t cin  [MAX_STAGES];
    tok_t cout [MAX_STAGES];
    logic [4:0] pos_reg, pos_next;
    logic run_reg, run_next;
    tok_t carry_reg, carry_next;

    // sequencer: feeds the token to one stage cell at a time
    logic [4:0] stg;
    logic [4:0] stg_cur;
    assign stg_cur = carry_reg.inverse ? 5'(ncells - 5'd1 - pos_reg) : pos_reg;

    always_comb begin
        run_next   = run_reg;
        pos_next   = pos_reg;
        carry_next = carry_reg;
        tail       = '0;
        stg        = stg_cur;
        for (int i = 0; i < MAX_STAGES; i++) begin
            cin[i] = '0;
        end
        if (head.valid) begin
            carry_next = head;
            carry_next.valid = 1'b0;
            pos_next = '0;
            if (ncells == 5'd0) begin
                tail = head;
            end else begin
                run_next = 1'b1;
                stg = head.inverse ? 5'(ncells - 5'd1) : 5'd0;
                for (int i = 0; i < MAX_STAGES; i++)
                    if (5'(i) == stg) cin[i] = head;
            end
        end else if (run_reg) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                if (5'(i) == stg_cur && cout[i].valid) begin
                    carry_next = cout[i];
                    carry_next.valid = 1'b0;
                    if (pos_reg + 5'd1 == ncells) begin
                        tail = cout[i];
                        run_next = 1'b0;
                    end else begin
                        pos_next = pos_reg + 5'd1;
                    end
                end
            end
            if (run_next && pos_next != pos_reg) begin
                stg = carry_reg.inverse ? 5'(ncells - 5'd2 - pos_reg) : 5'(pos_reg + 5'd1);
                for (int i = 0; i < MAX_STAGES; i++)
                    if (5'(i) == stg) begin
                        cin[i] = carry_next;
                        cin[i].valid = 1'b1;
                    end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) run_reg <= 1'b0;
        else run_reg <= run_next;
        pos_reg   <= pos_next;
        carry_reg <= carry_next;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_STAGES; g++) begin : g_cell
            crr_cell #(.SLOTS(SLOTS_PER_STAGE), .STAGE_NUM(g)) u_cell (
                .aclk, .aresetn, .wr, .tok_in(cin[g]), .tok_out(cout[g])
            );
        end
    endgenerate

    assign m_tdata = {4'd0, mc, mv};
endmodule

// ----- test/chained_range_remap_test.sv -----
// chained_range_remap_test: self-checking testbench for the chained range remap block.
// Drives loads and lookups with random gaps and stalls; a scoreboard predicts results.
// Depends on crr_pkg and chained_range_remap.
`timescale 1ns / 1ps
module chained_range_remap_test;
    import crr_pkg::*;

    localparam int WIN_TOTAL = MAX_STAGES_DEF * SLOTS_PER_STAGE_DEF;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } remap_result_t;

    class remap_scoreboard;
        logic [VAL_W-1:0] win_src [WIN_TOTAL];
        logic [VAL_W-1:0] win_dst [WIN_TOTAL];
        logic [VAL_W-1:0] win_len [WIN_TOTAL];
        bit               win_ok  [WIN_TOTAL];
        int unsigned      stage_count;
        remap_result_t    pending[$];
        int               errors;

        function void clear();
            foreach (win_ok[i]) win_ok[i] = 0;
            stage_count = 1;
            pending.delete();
            errors = 0;
        endfunction

        function logic [VAL_W-1:0] map_stage(int st, logic [VAL_W-1:0] v, bit inv,
                                             output bit hit);
            logic [32:0] from;
            logic [32:0] to;
            logic [32:0] stop;
            logic [32:0] r;
            int idx;
            hit = 0;
            for (int s = 0; s < SLOTS_PER_STAGE_DEF; s++) begin
                idx = st * SLOTS_PER_STAGE_DEF + s;
                if (!win_ok[idx]) continue;
                from = {1'b0, inv ? win_dst[idx] : win_src[idx]};
                to   = {1'b0, inv ? win_src[idx] : win_dst[idx]};
                stop = from + {1'b0, win_len[idx]};
                if ({1'b0, v} < from || {1'b0, v} >= stop) continue;
                r = to + ({1'b0, v} - from);
                if (r != {1'b0, v}) begin
                    hit = 1;
                    return r[32] ? '1 : r[31:0];
                end
            end
            return v;
        endfunction

        function void note_input(logic [1:0] u, logic [135:0] d);
            mode_t m;
            int n;
            int st;
            int idx;
            bit hit;
            logic [VAL_W-1:0] v;
            logic [CNT_W-1:0] cnt;
            m = mode_t'(u);
            if (m == MODE_LOAD) begin
                idx = d[2:0] * SLOTS_PER_STAGE_DEF + d[7:3];
                win_src[idx] = d[39:8];
                win_dst[idx] = d[71:40];
                win_len[idx] = d[103:72];
                win_ok[idx] = 1;
            end else if (m == MODE_FWD || m == MODE_INV) begin
                n = stage_count > MAX_STAGES_DEF ? MAX_STAGES_DEF : stage_count;
                v = d[135:104];
                cnt = 0;
                for (int k = 0; k < n; k++) begin
                    st = (m == MODE_FWD) ? k : n - 1 - k;
                    v = map_stage(st, v, m == MODE_INV, hit);
                    if (hit) cnt++;
                end
                pending.push_back('{value: v, count: cnt});
            end
        endfunction

        function void check_result(logic [39:0] d);
            remap_result_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result value=%h count=%0d", $time, d[31:0], d[35:32]);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.value) begin
                $display("%0t: result_value expected %h actual %h", $time, e.value, d[31:0]);
                errors++;
            end
            if (d[35:32] !== e.count) begin
                $display("%0t: changed_stages expected %0d actual %0d", $time, e.count,
                         d[35:32]);
                errors++;
            end
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         cfg_wr_en;
    logic [3:0]   cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;
    logic [135:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;

    remap_scoreboard sb;
    bit hold_off;
    logic [VAL_W-1:0] hot_vals[$];

    chained_range_remap dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #200ms;
        $display("** chained_range_remap: FAILED **");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // receiver: random stalls, plus one long hold-off
    initial begin
        int w;
        m_tready <= 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (3000) @(posedge aclk);
                hold_off = 0;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    task automatic send_item(mode_t m, int st, int sl, logic [31:0] src, logic [31:0] dst,
                             logic [31:0] len, logic [31:0] val, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 13) : 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= m;
        s_tdata <= {val, len, dst, src, sl[4:0], st[2:0]};
        @(posedge aclk iff s_tready);
    endtask

    task automatic send_load(int st, int sl, logic [31:0] src, logic [31:0] dst,
                             logic [31:0] len, bit gaps);
        send_item(MODE_LOAD, st, sl, src, dst, len, $urandom, gaps);
    endtask

    task automatic send_lookup(mode_t m, logic [31:0] val, bit gaps);
        send_item(m, $urandom, $urandom, $urandom, $urandom, $urandom, val, gaps);
    endtask

    task automatic drain_and_config(logic [3:0] n);
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_wr_data <= n;
        @(posedge aclk);
        cfg_wr_en <= 0;
        sb.stage_count = n;
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return '1;
            2: return 0;
            default: return hot_vals.size() ? hot_vals[$urandom_range(0, hot_vals.size()-1)]
                                              + $urandom_range(0, 3) - 1 : $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] l;
        int r;
        sb = new();
        sb.clear();
        aresetn = 0;
        cfg_wr_en = 0;
        cfg_wr_data = 0;
        s_tvalid = 0;
        s_tuser = '0;
        s_tdata = '0;
        hold_off = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty table, identity window, overflow, extremes, unused mode
        send_lookup(MODE_FWD, 32'h1234, 0);
        send_lookup(MODE_INV, '1, 0);
        send_load(0, 0, 100, 100, 50, 0);
        send_load(0, 1, 90, 1000, 40, 0);
        send_load(0, 31, 32'hFFFF_FFF0, 32'hFFFF_FFF0, '1, 0);
        send_load(1, 0, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h200, 0);
        send_load(7, 31, 0, 32'h8000_0000, '1, 0);
        send_load(7, 30, '1, 0, 0, 0);
        send_lookup(MODE_FWD, 110, 0);
        send_lookup(MODE_FWD, 89, 0);
        send_lookup(MODE_FWD, 129, 0);
        send_lookup(MODE_INV, 1010, 0);
        send_item(MODE_NONE, 7, 31, '1, '1, '1, '1, 0);
        drain_and_config(8);
        send_lookup(MODE_FWD, 32'hFFFF_FF10, 0);
        send_lookup(MODE_INV, 32'h8000_0005, 0);
        send_lookup(MODE_FWD, '1, 0);
        send_lookup(MODE_FWD, 0, 0);
        drain_and_config(0);
        send_lookup(MODE_FWD, 110, 0);
        drain_and_config(15);
        send_lookup(MODE_INV, 1010, 0);
        send_lookup(MODE_FWD, 32'hFFFF_FFFF, 0);

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            drain_and_config(ph == 5 ? 8 : $urandom_range(0, 15));
            if (ph == 2) hold_off = 1;
            for (int i = 0; i < 200; i++) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    a = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
                    b = ($urandom_range(0, 4) == 0) ? a : ($urandom_range(0, 3) == 0 ?
                        $urandom : $urandom_range(0, 4000));
                    l = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 300);
                    hot_vals.push_back(a);
                    hot_vals.push_back(b);
                    if (hot_vals.size() > 40) begin
                        void'(hot_vals.pop_front());
                        void'(hot_vals.pop_front());
                    end
                    send_load($urandom_range(0, 7), $urandom_range(0, 31), a, b, l, 1);
                end else if (r < 95) begin
                    send_lookup($urandom_range(0, 1) ? MODE_FWD : MODE_INV, pick_value(),
                                $urandom_range(0, 2) != 0);
                end else begin
                    send_item(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom, 1);
                end
            end
        end

        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** chained_range_remap: PASSED **");
        end else begin
            $display("** chained_range_remap: FAILED **");
        end
        $finish;
    end
endmodule
